@@ rtl/lpr_pkg.sv @@
// Shared types and constants for the line pixel rasteriser.
// No dependencies; every other file in rtl imports this package.
package lpr_pkg;

    localparam int COLOR_BITS = 16;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

endpackage

@@ rtl/lpr_if.sv @@
// Valid/ready channel interfaces for the command and pixel sides of the rasteriser.
// Depends on lpr_pkg for the operation type and the colour width.
interface lpr_cmd_if import lpr_pkg::*; #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    t_op                   operation;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] line_color;

    modport source (
        output valid, operation, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );
    modport sink (
        input  valid, operation, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

interface lpr_pix_if import lpr_pkg::*; #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

@@ rtl/lpr_setup.sv @@
// Line setup: picks the major axis, direction, span and signed minor delta
// from two endpoints. Purely combinational; depends on lpr_pkg.
module lpr_setup import lpr_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]        i_x0,
    input  logic [COORD_BITS-1:0]        i_y0,
    input  logic [COORD_BITS-1:0]        i_x1,
    input  logic [COORD_BITS-1:0]        i_y1,
    output logic                         o_steep,
    output logic [COORD_BITS-1:0]        o_major_start,
    output logic [COORD_BITS-1:0]        o_major_end,
    output logic                         o_major_dir,
    output logic [COORD_BITS-1:0]        o_major_span,
    output logic [COORD_BITS-1:0]        o_minor_start,
    output logic signed [COORD_BITS:0]   o_minor_delta
);
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]        adx_w;
    logic [COORD_BITS:0]        ady_w;
    logic [COORD_BITS-1:0]      adx;
    logic [COORD_BITS-1:0]      ady;

    always_comb begin
        dx    = $signed({1'b0, i_x1}) - $signed({1'b0, i_x0});
        dy    = $signed({1'b0, i_y1}) - $signed({1'b0, i_y0});
        adx_w = dx[COORD_BITS] ? -dx : dx;
        ady_w = dy[COORD_BITS] ? -dy : dy;
        // A difference of two unsigned coordinates never exceeds the coordinate range.
        adx   = adx_w[COORD_BITS-1:0];
        ady   = ady_w[COORD_BITS-1:0];

        // A vertical line, a single point included, always steps along y.
        o_steep = (dx == '0) || (ady > adx);
        if (o_steep) begin
            o_major_start = i_y0;
            o_major_end   = i_y1;
            o_major_dir   = dy[COORD_BITS];
            o_major_span  = ady;
            o_minor_start = i_x0;
            o_minor_delta = dx;
        end else begin
            o_major_start = i_x0;
            o_major_end   = i_x1;
            o_major_dir   = dx[COORD_BITS];
            o_major_span  = adx;
            o_minor_start = i_y0;
            o_minor_delta = dy;
        end
    end
endmodule

@@ rtl/line_pixel_rasterizer.sv @@
// Line rasteriser top level: input register, stepping state and pixel result register.
// Depends on lpr_pkg, lpr_if (lpr_cmd_if, lpr_pix_if) and lpr_setup.

// One command item is taken every cycle while the pixel side keeps up. An item
// is held in the input register, then worked by the setup logic or by the
// remainder step (an add of the minor delta, a compare against the span and at
// most one correction) and lands in the pixel result register. A start emits
// the start point; each step emits the next pixel and the end point is flagged
// with last_pixel, after which steps are dropped with no pixel. A start while a
// line is running abandons that line. Both endpoints are drawn.
module line_pixel_rasterizer import lpr_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpr_cmd_if.sink    i_cmd,
    lpr_pix_if.source  o_pix
);
    // Input register.
    logic                  r_in_valid;
    t_op                   r_in_op;
    logic [COORD_BITS-1:0] r_in_x0;
    logic [COORD_BITS-1:0] r_in_y0;
    logic [COORD_BITS-1:0] r_in_x1;
    logic [COORD_BITS-1:0] r_in_y1;
    logic [COLOR_BITS-1:0] r_in_color;

    // Line state.
    logic                       r_active,      n_active;
    logic                       r_steep,       n_steep;
    logic [COORD_BITS-1:0]      r_major_pos,   n_major_pos;
    logic [COORD_BITS-1:0]      r_minor_pos,   n_minor_pos;
    logic [COORD_BITS-1:0]      r_major_end,   n_major_end;
    logic                       r_major_dir,   n_major_dir;
    logic [COORD_BITS-1:0]      r_major_span,  n_major_span;
    logic signed [COORD_BITS:0] r_minor_delta, n_minor_delta;
    logic signed [COORD_BITS:0] r_rem,         n_rem;
    logic [COLOR_BITS-1:0]      r_color,       n_color;
    logic                       n_last;

    // Result register.
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_last;

    logic advance;
    logic fire;
    logic emit;

    logic                       su_steep;
    logic [COORD_BITS-1:0]      su_major_start;
    logic [COORD_BITS-1:0]      su_major_end;
    logic                       su_major_dir;
    logic [COORD_BITS-1:0]      su_major_span;
    logic [COORD_BITS-1:0]      su_minor_start;
    logic signed [COORD_BITS:0] su_minor_delta;

    logic signed [COORD_BITS+1:0] rem_sum;
    logic signed [COORD_BITS+1:0] span_ext;
    logic signed [COORD_BITS+1:0] rem_adj;

    assign advance     = !r_out_valid || o_pix.ready;
    assign fire        = r_in_valid && advance;
    assign emit        = fire && ((r_in_op == OP_START) || r_active);
    assign i_cmd.ready = !r_in_valid || advance;

    lpr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_x0          (r_in_x0),
        .i_y0          (r_in_y0),
        .i_x1          (r_in_x1),
        .i_y1          (r_in_y1),
        .o_steep       (su_steep),
        .o_major_start (su_major_start),
        .o_major_end   (su_major_end),
        .o_major_dir   (su_major_dir),
        .o_major_span  (su_major_span),
        .o_minor_start (su_minor_start),
        .o_minor_delta (su_minor_delta)
    );

    always_comb begin
        n_active      = r_active;
        n_steep       = r_steep;
        n_major_pos   = r_major_pos;
        n_minor_pos   = r_minor_pos;
        n_major_end   = r_major_end;
        n_major_dir   = r_major_dir;
        n_major_span  = r_major_span;
        n_minor_delta = r_minor_delta;
        n_rem         = r_rem;
        n_color       = r_color;
        n_last        = 1'b0;

        rem_sum  = {r_rem[COORD_BITS], r_rem} + {r_minor_delta[COORD_BITS], r_minor_delta};
        span_ext = $signed({2'b00, r_major_span});
        rem_adj  = rem_sum;

        if (fire) begin
            if (r_in_op == OP_START) begin
                n_steep       = su_steep;
                n_major_pos   = su_major_start;
                n_major_end   = su_major_end;
                n_major_dir   = su_major_dir;
                n_major_span  = su_major_span;
                n_minor_pos   = su_minor_start;
                n_minor_delta = su_minor_delta;
                n_rem         = '0;
                n_color       = r_in_color;
                n_last        = (su_major_start == su_major_end);
                n_active      = !n_last;
            end else if (r_active) begin
                n_major_pos = r_major_dir ? r_major_pos - 1'b1 : r_major_pos + 1'b1;
                // The remainder stays in [0, span), so one correction always suffices.
                if ((rem_sum >= span_ext) && (r_major_span != '0)) begin
                    rem_adj     = rem_sum - span_ext;
                    n_minor_pos = r_minor_pos + 1'b1;
                end else if (rem_sum < 0) begin
                    rem_adj     = rem_sum + span_ext;
                    n_minor_pos = r_minor_pos - 1'b1;
                end
                n_rem    = rem_adj[COORD_BITS:0];
                n_last   = (n_major_pos == r_major_end);
                n_active = !n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_active <= n_active;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_op    <= i_cmd.operation;
            r_in_x0    <= i_cmd.start_x;
            r_in_y0    <= i_cmd.start_y;
            r_in_x1    <= i_cmd.end_x;
            r_in_y1    <= i_cmd.end_y;
            r_in_color <= i_cmd.line_color;
        end
        r_steep       <= n_steep;
        r_major_pos   <= n_major_pos;
        r_minor_pos   <= n_minor_pos;
        r_major_end   <= n_major_end;
        r_major_dir   <= n_major_dir;
        r_major_span  <= n_major_span;
        r_minor_delta <= n_minor_delta;
        r_rem         <= n_rem;
        r_color       <= n_color;
        if (emit) begin
            r_out_x     <= n_steep ? n_minor_pos : n_major_pos;
            r_out_y     <= n_steep ? n_major_pos : n_minor_pos;
            r_out_color <= n_color;
            r_out_last  <= n_last;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_out_x;
    assign o_pix.pixel_y     = r_out_y;
    assign o_pix.pixel_color = r_out_color;
    assign o_pix.last_pixel  = r_out_last;
endmodule

@@ sim/tb_line_pixel_rasterizer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for line_pixel_rasterizer: drives start and step items on the
// command channel, predicts every pixel with exact remainder stepping and checks the pixel channel.
// Depends on lpr_pkg, the lpr_cmd_if / lpr_pix_if interfaces and the rasteriser RTL.
module tb_line_pixel_rasterizer import lpr_pkg::*;;

    localparam int COORD_BITS  = 10;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord                x;
        t_coord                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_pixel;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_BURSTY
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    lpr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();
    lpr_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

    line_pixel_rasterizer #(.COORD_BITS(COORD_BITS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_pix   (pix_bus)
    );

    // Predicted line state.
    logic                    ln_active;
    logic                    ln_steep;
    t_coord                  maj_pos;
    t_coord                  min_pos;
    t_coord                  maj_end;
    logic                    maj_down;
    int                      maj_span;
    logic signed [COORD_BITS:0] min_delta;
    int                      rem_acc;
    logic [COLOR_BITS-1:0]   ln_color;

    t_pixel   pending_pixels[$];
    int       err_count;
    int       cycle_count;
    int       pixels_predicted;
    int       pixels_checked;
    int       lines_started;
    int       steep_lines;
    int       idle_steps;

    // Sender and receiver pacing.
    t_rx_mode rx_mode;
    int       gap_max;
    int       burst_left;
    int       long_hold_req;
    int       hold_left;
    int       rx_phase;
    int       rx_run;
    logic     rx_run_stalled;

    always #5 i_clk = ~i_clk;

    // Works out the pixel that one command causes, if any, and advances the line state.
    function automatic logic rasterize_cmd(input t_op op, input t_coord sx, input t_coord sy,
                                           input t_coord ex, input t_coord ey,
                                           input logic [COLOR_BITS-1:0] col,
                                           output t_pixel pix);
        int   dx;
        int   dy;
        int   adx;
        int   ady;
        logic last;
        if (op == OP_START) begin
            dx  = int'(ex) - int'(sx);
            dy  = int'(ey) - int'(sy);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            ln_color = col;
            ln_steep = (dx == 0) || (ady > adx);
            if (ln_steep) begin
                maj_pos   = sy;
                maj_end   = ey;
                maj_down  = (dy < 0);
                maj_span  = ady;
                min_pos   = sx;
                min_delta = (COORD_BITS+1)'(dx);
            end else begin
                maj_pos   = sx;
                maj_end   = ex;
                maj_down  = (dx < 0);
                maj_span  = adx;
                min_pos   = sy;
                min_delta = (COORD_BITS+1)'(dy);
            end
            rem_acc   = 0;
            last      = (maj_pos == maj_end);
            ln_active = !last;
            lines_started++;
            if (ln_steep)
                steep_lines++;
        end else begin
            if (!ln_active) begin
                idle_steps++;
                return 1'b0;
            end
            maj_pos = maj_down ? maj_pos - 1'b1 : maj_pos + 1'b1;
            rem_acc += int'(min_delta);
            // One correction per step keeps the remainder in [0, span).
            if (rem_acc >= maj_span && maj_span != 0) begin
                rem_acc -= maj_span;
                min_pos = min_pos + 1'b1;
            end else if (rem_acc < 0) begin
                rem_acc += maj_span;
                min_pos = min_pos - 1'b1;
            end
            last = (maj_pos == maj_end);
            if (last)
                ln_active = 1'b0;
        end
        pix.x     = ln_steep ? min_pos : maj_pos;
        pix.y     = ln_steep ? maj_pos : min_pos;
        pix.color = ln_color;
        pix.last  = last;
        return 1'b1;
    endfunction

    // Accepted commands feed the predictor; accepted pixels are checked against the oldest one.
    always @(posedge i_clk) begin
        t_pixel exp_pix;
        t_pixel got_pix;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            if (rasterize_cmd(cmd_bus.operation, cmd_bus.start_x, cmd_bus.start_y,
                              cmd_bus.end_x, cmd_bus.end_y, cmd_bus.line_color, exp_pix)) begin
                pending_pixels.push_back(exp_pix);
                pixels_predicted++;
            end
        end
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            got_pix.x     = pix_bus.pixel_x;
            got_pix.y     = pix_bus.pixel_y;
            got_pix.color = pix_bus.pixel_color;
            got_pix.last  = pix_bus.last_pixel;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d colour=%h last=%0b", $time,
                         got_pix.x, got_pix.y, got_pix.color, got_pix.last);
                err_count++;
            end else begin
                exp_pix = pending_pixels.pop_front();
                pixels_checked++;
                if (got_pix.x !== exp_pix.x) begin
                    $display("%0t: pixel_x expected %0d actual %0d", $time, exp_pix.x, got_pix.x);
                    err_count++;
                end
                if (got_pix.y !== exp_pix.y) begin
                    $display("%0t: pixel_y expected %0d actual %0d", $time, exp_pix.y, got_pix.y);
                    err_count++;
                end
                if (got_pix.color !== exp_pix.color) begin
                    $display("%0t: pixel_color expected %h actual %h", $time,
                             exp_pix.color, got_pix.color);
                    err_count++;
                end
                if (got_pix.last !== exp_pix.last) begin
                    $display("%0t: last_pixel expected %0b actual %0b", $time,
                             exp_pix.last, got_pix.last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d pixels outstanding", cycle_count,
                     pending_pixels.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Pixel receiver: a long hold-off when asked for, otherwise the current stall pattern.
    always @(negedge i_clk) begin
        if (long_hold_req != 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
        end
        if (hold_left > 0) begin
            pix_bus.ready = 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    pix_bus.ready = 1'b1;
                end
                RX_RANDOM: begin
                    pix_bus.ready = 1'($urandom_range(0, 1));
                end
                RX_PATTERN: begin
                    rx_phase      = (rx_phase + 1) % 7;
                    pix_bus.ready = (rx_phase < 4);
                end
                default: begin
                    if (rx_run == 0) begin
                        rx_run         = $urandom_range(1, 10);
                        rx_run_stalled = ($urandom_range(0, 2) == 0);
                    end
                    rx_run--;
                    pix_bus.ready = !rx_run_stalled;
                end
            endcase
        end
    end

    // Offers one item and returns at the falling edge after it is taken, valid still high.
    task automatic send_cmd(input t_op op, input int sx, input int sy, input int ex,
                            input int ey, input int col);
        cmd_bus.operation  = op;
        cmd_bus.start_x    = t_coord'(sx);
        cmd_bus.start_y    = t_coord'(sy);
        cmd_bus.end_x      = t_coord'(ex);
        cmd_bus.end_y      = t_coord'(ey);
        cmd_bus.line_color = COLOR_BITS'(col);
        cmd_bus.valid      = 1'b1;
        do
            @(posedge i_clk);
        while (!cmd_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        cmd_bus.valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Ends a burst now and then with a gap of random length.
    task automatic pace_sender();
        if (gap_max == 0)
            return;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            idle_cycles($urandom_range(1, gap_max));
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic wait_for_pixels();
        cmd_bus.valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_step();
        send_cmd(OP_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, 16'hFFFF));
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return COORD_MAX;
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    function automatic int signed_offset(input int r);
        int v;
        v = $urandom_range(0, 2 * r);
        return v - r;
    endfunction

    // Draws a whole line, a cut-short one, or one followed by stray steps.
    task automatic draw_random_line();
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        int dx;
        int dy;
        int span;
        int n_steps;
        int style;
        kind = $urandom_range(0, 99);
        sx   = pick_coord();
        sy   = pick_coord();
        if (kind < 3) begin
            dx = signed_offset(400);
            dy = signed_offset(400);
        end else if (kind < 10) begin
            case ($urandom_range(0, 2))
                0:       begin dx = 0; dy = signed_offset(24); end
                1:       begin dx = signed_offset(24); dy = 0; end
                default: begin dx = 0; dy = 0; end
            endcase
        end else if (kind < 16) begin
            dx = signed_offset(20);
            dy = ($urandom_range(0, 1) == 1) ? dx : -dx;
        end else begin
            dx = signed_offset(24);
            dy = signed_offset(24);
        end
        ex   = clamp_coord(sx + dx);
        ey   = clamp_coord(sy + dy);
        dx   = (ex > sx) ? ex - sx : sx - ex;
        dy   = (ey > sy) ? ey - sy : sy - ey;
        span = (dx > dy) ? dx : dy;
        style = $urandom_range(0, 9);
        if (style == 0 && span > 0)
            n_steps = $urandom_range(0, span - 1);
        else if (style == 1)
            n_steps = span + $urandom_range(1, 3);
        else
            n_steps = span;
        send_cmd(OP_START, sx, sy, ex, ey, $urandom_range(0, 16'hFFFF));
        pace_sender();
        repeat (n_steps) begin
            send_step();
            pace_sender();
        end
    endtask

    task automatic test_idle_step();
        send_step();
        wait_for_pixels();
    endtask

    task automatic test_single_points();
        send_cmd(OP_START, 0, 0, 0, 0, 16'h0000);
        send_cmd(OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
        wait_for_pixels();
    endtask

    task automatic test_line_shapes();
        // Shallow right to left from the corner, steep bottom to top, vertical, diagonal.
        send_cmd(OP_START, COORD_MAX, 0, COORD_MAX - 3, 2, 16'hA5A5);
        repeat (3) send_step();
        send_cmd(OP_START, 0, COORD_MAX, 2, COORD_MAX - 4, 16'h5A5A);
        repeat (4) send_step();
        send_cmd(OP_START, 5, 5, 5, 7, 16'h07E0);
        repeat (2) send_step();
        send_cmd(OP_START, 10, 10, 12, 8, 16'hF800);
        repeat (2) send_step();
        wait_for_pixels();
    endtask

    task automatic test_restart();
        // A start mid-line drops the old line; the step after the end point is ignored.
        send_cmd(OP_START, 0, 0, 4, 4, 16'h001F);
        send_step();
        send_cmd(OP_START, 100, 200, 101, 200, 16'h1234);
        send_step();
        send_step();
        wait_for_pixels();
    endtask

    task automatic test_output_stall();
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        send_cmd(OP_START, 10, 20, 90, 50, 16'hC3C3);
        long_hold_req = 250;
        repeat (80) send_step();
        wait_for_pixels();
    endtask

    task automatic test_random_lines(input int target);
        int phase;
        int goal;
        for (phase = 0; phase < 4; phase++) begin
            rx_mode    = t_rx_mode'(phase);
            gap_max    = (phase == 0) ? 0 : (phase == 2) ? 3 : 8;
            burst_left = 0;
            goal       = pixels_predicted + target / 4;
            while (pixels_predicted < goal)
                draw_random_line();
            wait_for_pixels();
        end
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.operation  = OP_START;
        cmd_bus.start_x    = '0;
        cmd_bus.start_y    = '0;
        cmd_bus.end_x      = '0;
        cmd_bus.end_y      = '0;
        cmd_bus.line_color = '0;
        pix_bus.ready      = 1'b0;
        ln_active = 1'b0;
        ln_steep  = 1'b0;
        maj_pos   = '0;
        min_pos   = '0;
        maj_end   = '0;
        maj_down  = 1'b0;
        maj_span  = 0;
        min_delta = '0;
        rem_acc   = 0;
        ln_color  = '0;
        err_count = 0;
        cycle_count = 0;
        pixels_predicted = 0;
        pixels_checked = 0;
        lines_started = 0;
        steep_lines = 0;
        idle_steps = 0;
        rx_mode = RX_RANDOM;
        gap_max = 0;
        burst_left = 0;
        long_hold_req = 0;
        hold_left = 0;
        rx_phase = 0;
        rx_run = 0;
        rx_run_stalled = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_idle_step();
        test_single_points();
        test_line_shapes();
        test_restart();
        test_output_stall();
        test_random_lines(920);

        wait_for_pixels();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d lines (%0d steep) and %0d checked pixels in %0d cycles;",
                 lines_started, steep_lines, pixels_checked, cycle_count);
        $display("%0d steps arrived with no line active and were ignored.", idle_steps);
        if (err_count == 0 && pending_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
